@@ hdl/v2alu_pkg.sv @@
// ----------------------------------------------------------------------------
// v2alu_pkg
// Shared constants, types and arithmetic helpers of the 2D vector unit.
// ----------------------------------------------------------------------------
package v2alu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;

   // derived widths
   localparam int NUM_W  = WORD_BITS + FRAC_BITS;  // divider numerator / quotient
   localparam int RS_W   = WORD_BITS + 3;          // square root partial remainder
   localparam int WIDE_W = 2 * WORD_BITS + 2;      // exact intermediate results
   localparam int V_W    = FRAC_BITS + 2;          // unit vector component
   localparam int D_W    = FRAC_BITS + 4;          // doubled dot product of unit vectors

   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_SCALE = 3'd2,
      OP_DIV   = 3'd3,
      OP_DOT   = 3'd4,
      OP_LEN   = 3'd5,
      OP_NORM  = 3'd6,
      OP_REFL  = 3'd7
   } op_type;

   // one square root lane, one radicand bit pair per cell
   typedef struct packed {
      logic [2*WORD_BITS-1:0] rad;
      logic [RS_W-1:0]        rem;
      logic [WORD_BITS-1:0]   root;
   } sqrt_type;

   // one divider lane, one quotient bit per cell
   typedef struct packed {
      logic [NUM_W-1:0]     num;
      logic [WORD_BITS-1:0] rem;
      logic [WORD_BITS-1:0] den;
      logic [NUM_W-1:0]     quo;
   } div_type;

   // request operands and the results settled so far
   typedef struct packed {
      op_type                      kind;
      logic signed [WORD_BITS-1:0] ax;
      logic signed [WORD_BITS-1:0] ay;
      logic signed [WORD_BITS-1:0] bx;
      logic signed [WORD_BITS-1:0] by;
      logic signed [WORD_BITS-1:0] f;
      logic signed [WORD_BITS-1:0] res_x;
      logic signed [WORD_BITS-1:0] res_y;
      logic signed [WORD_BITS-1:0] res_s;
      logic                        sat;
      logic                        dz;
   } side_type;

   // reflect tail
   typedef struct packed {
      logic signed [V_W-1:0]     vx;
      logic signed [V_W-1:0]     vy;
      logic signed [V_W-1:0]     nx;
      logic signed [V_W-1:0]     ny;
      logic signed [2*V_W-1:0]   p1;
      logic signed [2*V_W-1:0]   p2;
      logic signed [D_W-1:0]     d;
      logic signed [D_W+V_W-1:0] dnx;
      logic signed [D_W+V_W-1:0] dny;
   } refl_type;

   localparam logic signed [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   // clip to the word range; returns {clipped, value}
   function automatic logic [WORD_BITS:0] sat_w(input wide_type v);
      wide_type hi;
      wide_type lo;
      hi = wide_type'({1'b0, {(WORD_BITS-1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
         return {1'b1, SMAX};
      end else if (v < lo) begin
         return {1'b1, SMIN};
      end
      return {1'b0, v[WORD_BITS-1:0]};
   endfunction

   // shift right by the fraction width, round to nearest, ties up
   function automatic wide_type rnd_shr(input wide_type v);
      wide_type half;
      half = wide_type'(1) <<< (FRAC_BITS - 1);
      return (v + half) >>> FRAC_BITS;
   endfunction

   function automatic logic [WORD_BITS-1:0] abs_w(input logic signed [WORD_BITS-1:0] v);
      return v[WORD_BITS-1] ? WORD_BITS'(~v + 1'b1) : WORD_BITS'(v);
   endfunction

   // apply sign to an unsigned quotient
   function automatic wide_type sgn_q(input logic [NUM_W-1:0] q, input logic neg);
      wide_type m;
      m = wide_type'({1'b0, q});
      return neg ? -m : m;
   endfunction

endpackage

@@ hdl/vector2_alu_top.sv @@
// ----------------------------------------------------------------------------
// vector2_alu_top
// Signed fixed-point 2D vector unit: add, sub, scale, divide, dot, length,
// normalize and reflect, with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
// Fully pipelined: one request is accepted every cycle while the pipeline is
// not held. The depth is set by the row of square root cells (one root bit per
// cell, 32 cells) followed by the row of divider cells (one quotient bit per
// cell, 48 cells), plus front multiply and reflect tail stages. All requests
// take the same path, so results come out in order. When the result register
// is full and not taken, the whole pipeline holds and req_ready drops; it rises
// again the cycle the result is taken.
module vector2_alu_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [2:0]                            req_kind,
   input  logic signed [v2alu_pkg::WORD_BITS-1:0] req_a_x,
   input  logic signed [v2alu_pkg::WORD_BITS-1:0] req_a_y,
   input  logic signed [v2alu_pkg::WORD_BITS-1:0] req_b_x,
   input  logic signed [v2alu_pkg::WORD_BITS-1:0] req_b_y,
   input  logic signed [v2alu_pkg::WORD_BITS-1:0] req_factor,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [v2alu_pkg::WORD_BITS-1:0] rsp_res_x,
   output logic signed [v2alu_pkg::WORD_BITS-1:0] rsp_res_y,
   output logic signed [v2alu_pkg::WORD_BITS-1:0] rsp_res_scalar,
   output logic                                  rsp_saturated,
   output logic                                  rsp_div_zero
);
   import v2alu_pkg::*;

   localparam int STG_MUL = 1;
   localparam int STG_SUM = 2;
   localparam int STG_SET = STG_SUM + WORD_BITS + 1;
   localparam int STG_E   = STG_SET + NUM_W + 1;
   localparam int NSTG    = STG_E + 4;

   logic                            en;
   logic [NSTG-1:0]                 vld_ff;
   side_type                        side_ff [NSTG];
   side_type                        side_in [NSTG];

   logic signed [2*WORD_BITS-1:0]   pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [WORD_BITS-1:0]     mul_a, mul_b;
   logic [2*WORD_BITS-1:0]          sa_ff, sb_ff;
   logic [WORD_BITS:0]              sum_x, sum_y, sum_s;

   sqrt_type                        sq_chain  [2][WORD_BITS+1];
   div_type                         div_chain [4][NUM_W+1];
   div_type                         set_ff [4];
   div_type                         set_in [4];
   logic signed [WORD_BITS-1:0]     comp_v [4];
   logic [WORD_BITS-1:0]            len_a, len_b, abs_f;
   logic [WORD_BITS:0]              len_sat;

   wide_type                        qs [4];
   logic                            neg_v [4];
   logic [WORD_BITS:0]              e_x, e_y;
   logic                            zero_a, zero_b;

   refl_type                        refl_ff [4];
   refl_type                        refl_in [4];
   wide_type                        dot_w;
   logic [WORD_BITS:0]              out_x, out_y;

   logic                            rsp_valid_ff;
   logic signed [WORD_BITS-1:0]     rsp_x_ff, rsp_y_ff, rsp_s_ff;
   logic                            rsp_sat_ff, rsp_dz_ff;

   // whole pipeline moves unless a result waits
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // multiplier operand select: scale uses the factor, dot uses b, others square a
   always_comb begin
      case (side_ff[0].kind)
         OP_SCALE: begin
            mul_a = side_ff[0].f;
            mul_b = side_ff[0].f;
         end
         OP_DOT: begin
            mul_a = side_ff[0].bx;
            mul_b = side_ff[0].by;
         end
         default: begin
            mul_a = side_ff[0].ax;
            mul_b = side_ff[0].ay;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff <= side_ff[0].ax * mul_a;
         pb_ff <= side_ff[0].ay * mul_b;
         pc_ff <= side_ff[0].bx * side_ff[0].bx;
         pd_ff <= side_ff[0].by * side_ff[0].by;
         sa_ff <= $unsigned(pa_ff) + $unsigned(pb_ff);
         sb_ff <= $unsigned(pc_ff) + $unsigned(pd_ff);
      end
   end

   // results that settle right after the multipliers
   always_comb begin
      sum_x = '0;
      sum_y = '0;
      sum_s = '0;
      case (side_ff[STG_MUL].kind)
         OP_ADD: begin
            sum_x = sat_w(wide_type'(side_ff[STG_MUL].ax) + wide_type'(side_ff[STG_MUL].bx));
            sum_y = sat_w(wide_type'(side_ff[STG_MUL].ay) + wide_type'(side_ff[STG_MUL].by));
         end
         OP_SUB: begin
            sum_x = sat_w(wide_type'(side_ff[STG_MUL].ax) - wide_type'(side_ff[STG_MUL].bx));
            sum_y = sat_w(wide_type'(side_ff[STG_MUL].ay) - wide_type'(side_ff[STG_MUL].by));
         end
         OP_SCALE: begin
            sum_x = sat_w(rnd_shr(wide_type'(pa_ff)));
            sum_y = sat_w(rnd_shr(wide_type'(pb_ff)));
         end
         OP_DOT: begin
            sum_s = sat_w(rnd_shr(wide_type'(pa_ff) + wide_type'(pb_ff)));
         end
         default: begin
            sum_s = '0;
         end
      endcase
   end

   // square root rows for |a| and |b|
   assign sq_chain[0][0] = '{rad: sa_ff, rem: '0, root: '0};
   assign sq_chain[1][0] = '{rad: sb_ff, rem: '0, root: '0};

   for (genvar l = 0; l < 2; l++) begin : g_sq_lane
      for (genvar k = 0; k < WORD_BITS; k++) begin : g_sq_cell
         v2alu_sqrt_cell u_cell (
            .clock    (clock),
            .en       (en),
            .cell_in  (sq_chain[l][k]),
            .cell_out (sq_chain[l][k+1])
         );
      end
   end

   // divider setup: magnitude shifted up plus half the divisor for rounding
   always_comb begin
      len_a     = sq_chain[0][WORD_BITS].root;
      len_b     = sq_chain[1][WORD_BITS].root;
      len_sat   = sat_w(wide_type'({1'b0, len_a}));
      abs_f     = abs_w(side_ff[STG_SET-1].f);
      comp_v[0] = side_ff[STG_SET-1].ax;
      comp_v[1] = side_ff[STG_SET-1].ay;
      comp_v[2] = side_ff[STG_SET-1].bx;
      comp_v[3] = side_ff[STG_SET-1].by;
      for (int l = 0; l < 4; l++) begin
         if (side_ff[STG_SET-1].kind == OP_DIV) begin
            set_in[l].den = abs_f;
         end else begin
            set_in[l].den = (l < 2) ? len_a : len_b;
         end
         set_in[l].num = (NUM_W'(abs_w(comp_v[l])) << FRAC_BITS)
                         + NUM_W'(set_in[l].den >> 1);
         set_in[l].rem = '0;
         set_in[l].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         set_ff <= set_in;
      end
   end

   // divider rows: for divide, a_x, a_y, b_x, b_y all over |f|; else a_x, a_y over |a|, b_x, b_y over |b|
   for (genvar l = 0; l < 4; l++) begin : g_dv_lane
      assign div_chain[l][0] = set_ff[l];
      for (genvar k = 0; k < NUM_W; k++) begin : g_dv_cell
         v2alu_div_cell u_cell (
            .clock    (clock),
            .en       (en),
            .cell_in  (div_chain[l][k]),
            .cell_out (div_chain[l][k+1])
         );
      end
   end

   // signed quotients
   always_comb begin
      neg_v[0] = side_ff[STG_E-1].ax[WORD_BITS-1];
      neg_v[1] = side_ff[STG_E-1].ay[WORD_BITS-1];
      neg_v[2] = side_ff[STG_E-1].bx[WORD_BITS-1];
      neg_v[3] = side_ff[STG_E-1].by[WORD_BITS-1];
      for (int l = 0; l < 4; l++) begin
         qs[l] = sgn_q(div_chain[l][NUM_W].quo,
                       neg_v[l] ^ ((side_ff[STG_E-1].kind == OP_DIV)
                                   && side_ff[STG_E-1].f[WORD_BITS-1]));
      end
      zero_a = (side_ff[STG_E-1].ax == '0) && (side_ff[STG_E-1].ay == '0);
      zero_b = (side_ff[STG_E-1].bx == '0) && (side_ff[STG_E-1].by == '0);
   end

   // divide results; a zero factor pins by sign
   always_comb begin
      if (side_ff[STG_E-1].f == '0) begin
         e_x = {side_ff[STG_E-1].ax != '0,
                side_ff[STG_E-1].ax[WORD_BITS-1] ? SMIN :
                (side_ff[STG_E-1].ax != '0 ? SMAX : '0)};
         e_y = {side_ff[STG_E-1].ay != '0,
                side_ff[STG_E-1].ay[WORD_BITS-1] ? SMIN :
                (side_ff[STG_E-1].ay != '0 ? SMAX : '0)};
      end else begin
         e_x = sat_w(qs[0]);
         e_y = sat_w(qs[1]);
      end
   end

   // side band: pass along, fill in results where they settle
   always_comb begin
      side_in[0].kind  = op_type'(req_kind);
      side_in[0].ax    = req_a_x;
      side_in[0].ay    = req_a_y;
      side_in[0].bx    = req_b_x;
      side_in[0].by    = req_b_y;
      side_in[0].f     = req_factor;
      side_in[0].res_x = '0;
      side_in[0].res_y = '0;
      side_in[0].res_s = '0;
      side_in[0].sat   = 1'b0;
      side_in[0].dz    = 1'b0;
      for (int i = 1; i < NSTG; i++) begin
         side_in[i] = side_ff[i-1];
      end

      side_in[STG_SUM].res_x = sum_x[WORD_BITS-1:0];
      side_in[STG_SUM].res_y = sum_y[WORD_BITS-1:0];
      side_in[STG_SUM].res_s = sum_s[WORD_BITS-1:0];
      side_in[STG_SUM].sat   = sum_x[WORD_BITS] | sum_y[WORD_BITS] | sum_s[WORD_BITS];

      if (side_ff[STG_SET-1].kind == OP_LEN) begin
         side_in[STG_SET].res_s = len_sat[WORD_BITS-1:0];
         side_in[STG_SET].sat   = len_sat[WORD_BITS];
      end

      case (side_ff[STG_E-1].kind)
         OP_DIV: begin
            side_in[STG_E].res_x = e_x[WORD_BITS-1:0];
            side_in[STG_E].res_y = e_y[WORD_BITS-1:0];
            side_in[STG_E].sat   = e_x[WORD_BITS] | e_y[WORD_BITS];
            side_in[STG_E].dz    = (side_ff[STG_E-1].f == '0);
         end
         OP_NORM: begin
            side_in[STG_E].res_x = zero_a ? side_ff[STG_E-1].ax : qs[0][WORD_BITS-1:0];
            side_in[STG_E].res_y = zero_a ? side_ff[STG_E-1].ay : qs[1][WORD_BITS-1:0];
         end
         default: begin
            side_in[STG_E].dz = 1'b0;
         end
      endcase
   end

   // reflect tail: unit vectors, dot, doubled projection, subtract
   always_comb begin
      refl_in[0]    = '0;
      refl_in[0].vx = zero_a ? '0 : qs[0][V_W-1:0];
      refl_in[0].vy = zero_a ? '0 : qs[1][V_W-1:0];
      refl_in[0].nx = zero_b ? '0 : qs[2][V_W-1:0];
      refl_in[0].ny = zero_b ? '0 : qs[3][V_W-1:0];

      refl_in[1]    = refl_ff[0];
      refl_in[1].p1 = refl_ff[0].vx * refl_ff[0].nx;
      refl_in[1].p2 = refl_ff[0].vy * refl_ff[0].ny;

      refl_in[2]    = refl_ff[1];
      dot_w         = rnd_shr(wide_type'(refl_ff[1].p1) + wide_type'(refl_ff[1].p2)) <<< 1;
      refl_in[2].d  = dot_w[D_W-1:0];

      refl_in[3]     = refl_ff[2];
      refl_in[3].dnx = refl_ff[2].d * refl_ff[2].nx;
      refl_in[3].dny = refl_ff[2].d * refl_ff[2].ny;

      out_x = sat_w(wide_type'(refl_ff[3].vx) - rnd_shr(wide_type'(refl_ff[3].dnx)));
      out_y = sat_w(wide_type'(refl_ff[3].vy) - rnd_shr(wide_type'(refl_ff[3].dny)));
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         refl_ff <= refl_in;
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[NSTG-2:0], req_valid};
         rsp_valid_ff <= vld_ff[NSTG-1];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (en) begin
         if (side_ff[NSTG-1].kind == OP_REFL) begin
            rsp_x_ff   <= out_x[WORD_BITS-1:0];
            rsp_y_ff   <= out_y[WORD_BITS-1:0];
            rsp_s_ff   <= '0;
            rsp_sat_ff <= out_x[WORD_BITS] | out_y[WORD_BITS];
            rsp_dz_ff  <= 1'b0;
         end else begin
            rsp_x_ff   <= side_ff[NSTG-1].res_x;
            rsp_y_ff   <= side_ff[NSTG-1].res_y;
            rsp_s_ff   <= side_ff[NSTG-1].res_s;
            rsp_sat_ff <= side_ff[NSTG-1].sat;
            rsp_dz_ff  <= side_ff[NSTG-1].dz;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_res_x      = rsp_x_ff;
   assign rsp_res_y      = rsp_y_ff;
   assign rsp_res_scalar = rsp_s_ff;
   assign rsp_saturated  = rsp_sat_ff;
   assign rsp_div_zero   = rsp_dz_ff;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a held pipeline keeps its occupancy
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

   // divide by zero never reports a scalar
   a_dz_scalar: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_zero) |-> (rsp_res_scalar == '0))
      else $error("scalar set on divide by zero");

   // unclipped divide by zero means a zero vector
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_zero && !rsp_saturated) |->
      (rsp_res_x == '0 && rsp_res_y == '0))
      else $error("divide by zero result without clip flag");

endmodule

@@ hdl/v2alu_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// v2alu_sqrt_cell
// One digit step of an integer square root: takes two radicand bits and
// yields one root bit, registered toward the next cell.
// ----------------------------------------------------------------------------
module v2alu_sqrt_cell (
   input  logic                 clock,
   input  logic                 en,
   input  v2alu_pkg::sqrt_type  cell_in,
   output v2alu_pkg::sqrt_type  cell_out
);
   import v2alu_pkg::*;

   logic [RS_W-1:0] pre;
   logic [RS_W-1:0] trial;
   logic            take;
   sqrt_type        step_in;
   sqrt_type        step_ff;

   // bring down two radicand bits, try root*4+1
   always_comb begin
      pre          = {cell_in.rem[RS_W-3:0], cell_in.rad[2*WORD_BITS-1 -: 2]};
      trial        = RS_W'({cell_in.root, 2'b01});
      take         = (pre >= trial);
      step_in.rad  = cell_in.rad << 2;
      step_in.rem  = take ? (pre - trial) : pre;
      step_in.root = {cell_in.root[WORD_BITS-2:0], take};
   end

   // advance
   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign cell_out = step_ff;

endmodule

@@ hdl/v2alu_div_cell.sv @@
// ----------------------------------------------------------------------------
// v2alu_div_cell
// One restoring division step: shifts in one numerator bit, produces one
// quotient bit, registered toward the next cell.
// ----------------------------------------------------------------------------
module v2alu_div_cell (
   input  logic                clock,
   input  logic                en,
   input  v2alu_pkg::div_type  cell_in,
   output v2alu_pkg::div_type  cell_out
);
   import v2alu_pkg::*;

   logic [WORD_BITS:0] pre;
   logic [WORD_BITS:0] diff;
   logic               take;
   div_type            step_in;
   div_type            step_ff;

   // compare partial remainder with the divisor
   always_comb begin
      pre         = {cell_in.rem, cell_in.num[NUM_W-1]};
      diff        = pre - {1'b0, cell_in.den};
      take        = (pre >= {1'b0, cell_in.den});
      step_in.num = cell_in.num << 1;
      step_in.rem = take ? diff[WORD_BITS-1:0] : pre[WORD_BITS-1:0];
      step_in.den = cell_in.den;
      step_in.quo = {cell_in.quo[NUM_W-2:0], take};
   end

   // advance
   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign cell_out = step_ff;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// vector2_alu testbench
// Drives random and directed vector requests into the 2D vector unit, predicts
// every response with a fixed-point model and checks responses in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import v2alu_pkg::*;

   localparam int     N_RANDOM  = 1950;
   localparam int     LATENCY   = 89;
   localparam longint MAX_CYCLE = 400000;

   typedef struct {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] rs;
      logic               sat;
      logic               dz;
   } vec_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_kind = '0;
   logic signed [31:0] req_a_x = '0, req_a_y = '0, req_b_x = '0, req_b_y = '0;
   logic signed [31:0] req_factor = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_res_x, rsp_res_y, rsp_res_scalar;
   logic rsp_saturated, rsp_div_zero;

   int     n_errors = 0;
   longint cycle = 0;
   bit     rsp_idle_on = 1'b1;
   bit     hold_rsp = 1'b0;

   vector2_alu_top dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic report(input string what, input longint got, input longint want);
      n_errors++;
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle);
   endtask

   // ---------------- fixed-point vector math ----------------
   function automatic longint round_q(longint v);
      return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic longint div_round(longint n, longint d);
      longint un, ud, q;
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      q = (un + ud / 2) / ud;
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic longint dot_q(longint ax, longint ay, longint bx, longint by);
      longint p1, p2, l, half;
      p1 = ax * bx;
      p2 = ay * by;
      l = (p1 & 1) + (p2 & 1);
      half = (p1 >>> 1) + (p2 >>> 1) + (l >>> 1);
      return (half + (longint'(1) << (FRAC_BITS - 2))) >>> (FRAC_BITS - 1);
   endfunction

   function automatic longint vec_len(longint x, longint y);
      longint unsigned s, r, b;
      longint unsigned ux, uy;
      ux = x < 0 ? -x : x;
      uy = y < 0 ? -y : y;
      s = ux * ux + uy * uy;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic void unit_vec(longint x, longint y, output longint nx, output longint ny);
      longint len;
      len = vec_len(x, y);
      if (len == 0) begin
         nx = x;
         ny = y;
      end else begin
         nx = div_round(x << FRAC_BITS, len);
         ny = div_round(y << FRAC_BITS, len);
      end
   endfunction

   function automatic logic signed [31:0] clip(longint v, inout logic flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] div_part(longint a, longint f, inout logic flag);
      if (f == 0) begin
         if (a == 0) return '0;
         flag = 1'b1;
         return a > 0 ? 32'sh7fffffff : 32'sh80000000;
      end
      return clip(div_round(a << FRAC_BITS, f), flag);
   endfunction

   function automatic vec_result_type predict_vec(op_type k, longint ax, longint ay,
                                                  longint bx, longint by, longint f);
      vec_result_type r;
      longint vx, vy, nx, ny, d;
      r.rx = '0; r.ry = '0; r.rs = '0; r.sat = 1'b0; r.dz = 1'b0;
      case (k)
         OP_ADD: begin
            r.rx = clip(ax + bx, r.sat); r.ry = clip(ay + by, r.sat);
         end
         OP_SUB: begin
            r.rx = clip(ax - bx, r.sat); r.ry = clip(ay - by, r.sat);
         end
         OP_SCALE: begin
            r.rx = clip(round_q(ax * f), r.sat); r.ry = clip(round_q(ay * f), r.sat);
         end
         OP_DIV: begin
            r.dz = (f == 0);
            r.rx = div_part(ax, f, r.sat); r.ry = div_part(ay, f, r.sat);
         end
         OP_DOT: r.rs = clip(dot_q(ax, ay, bx, by), r.sat);
         OP_LEN: r.rs = clip(vec_len(ax, ay), r.sat);
         OP_NORM: begin
            unit_vec(ax, ay, vx, vy);
            r.rx = clip(vx, r.sat); r.ry = clip(vy, r.sat);
         end
         default: begin
            unit_vec(ax, ay, vx, vy);
            unit_vec(bx, by, nx, ny);
            d = 2 * dot_q(vx, vy, nx, ny);
            r.rx = clip(vx - round_q(d * nx), r.sat);
            r.ry = clip(vy - round_q(d * ny), r.sat);
         end
      endcase
      return r;
   endfunction

   // ---------------- scoreboard ----------------
   class vec_scoreboard;
      vec_result_type pending[$];

      function void note_request(logic [2:0] k, logic signed [31:0] ax, logic signed [31:0] ay,
                                 logic signed [31:0] bx, logic signed [31:0] by,
                                 logic signed [31:0] f);
         pending.push_back(predict_vec(op_type'(k), ax, ay, bx, by, f));
      endfunction

      task check_response(logic signed [31:0] x, logic signed [31:0] y,
                          logic signed [31:0] s, logic sat, logic dz);
         vec_result_type w;
         if (pending.size() == 0) begin
            report("unexpected response", 0, 0);
            return;
         end
         w = pending.pop_front();
         if (x !== w.rx) report("res_x", x, w.rx);
         if (y !== w.ry) report("res_y", y, w.ry);
         if (s !== w.rs) report("res_scalar", s, w.rs);
         if (sat !== w.sat) report("saturated", sat, w.sat);
         if (dz !== w.dz) report("div_zero", dz, w.dz);
      endtask
   endclass

   vec_scoreboard board = new();

   // sample both channels at the rising edge
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_request(req_kind, req_a_x, req_a_y, req_b_x, req_b_y, req_factor);
         if (rsp_valid && rsp_ready)
            board.check_response(rsp_res_x, rsp_res_y, rsp_res_scalar, rsp_saturated,
                                 rsp_div_zero);
      end
      if (cycle > MAX_CYCLE) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // drive response ready with idle bursts
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            @(negedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // present one request and hold it until accepted
   task automatic send_req(logic [2:0] k, logic [31:0] ax, logic [31:0] ay,
                           logic [31:0] bx, logic [31:0] by, logic [31:0] f);
      req_valid <= 1'b1;
      req_kind <= k; req_a_x <= ax; req_a_y <= ay;
      req_b_x <= bx; req_b_y <= by; req_factor <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_req(int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return '0;
         3: return 32'(int'($urandom_range(0, 131072)) - 65536);
         4: return 32'(int'($urandom_range(0, 33554432)) - 16777216);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      logic [31:0] M, N;
      M = 32'h7fffffff;
      N = 32'h80000000;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed requests: extremes, each op, zero length and zero divisor
      send_req(OP_ADD, M, N, M, N, 0);
      send_req(OP_SUB, M, N, N, M, 0);
      send_req(OP_ADD, 32'h10000, 32'h20000, 32'hffff0000, 32'h5, 0);
      send_req(OP_SCALE, M, N, 0, 0, M);
      send_req(OP_SCALE, 32'h18000, 32'hfffe8000, 0, 0, 32'h8000);
      send_req(OP_DIV, 32'h30000, 32'hfffd0000, 0, 0, 32'h20000);
      send_req(OP_DIV, M, N, 0, 0, 0);
      send_req(OP_DIV, 0, 32'h1, 0, 0, 0);
      send_req(OP_DIV, M, N, 0, 0, 1);
      send_req(OP_DOT, M, N, M, N, 0);
      send_req(OP_DOT, N, N, N, N, 0);
      send_req(OP_LEN, N, N, 0, 0, 0);
      send_req(OP_LEN, 32'h30000, 32'h40000, 0, 0, 0);
      send_req(OP_NORM, 0, 0, 0, 0, 0);
      send_req(OP_NORM, N, M, 0, 0, 0);
      send_req(OP_NORM, 1, 0, 0, 0, 0);
      send_req(OP_REFL, 32'h10000, 32'hffff0000, 0, 32'h10000, 0);
      send_req(OP_REFL, 32'h10000, 32'h10000, 0, 0, 0);
      send_req(OP_REFL, 0, 0, 32'h10000, 0, 0);
      send_req(OP_REFL, N, M, M, N, 0);

      // random requests; stall the receiver once and drain once midway
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 400) begin
            hold_rsp = 1'b1;
            fork
               begin
                  repeat (300) @(negedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         if (i == 900) begin
            idle_req(1);
            while (board.pending.size() != 0) @(negedge clock);
         end
         if (i == N_RANDOM - 300) rsp_idle_on = 1'b0;
         if (rsp_idle_on && $urandom_range(0, 7) == 0) idle_req($urandom_range(1, 19));
         send_req(3'($urandom_range(0, 7)), rand_word(), rand_word(), rand_word(),
                  rand_word(), rand_word());
      end
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 20) @(negedge clock);
      if (n_errors == 0 && board.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

@@ vector2_alu_top.f @@
hdl/v2alu_pkg.sv
hdl/v2alu_sqrt_cell.sv
hdl/v2alu_div_cell.sv
hdl/vector2_alu_top.sv
tb/tb.sv
